[rtl/http_response_header_parser_macros.svh]
// Assertion macros shared by the header parser modules.
`ifndef HTTP_RESPONSE_HEADER_PARSER_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HRHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HRHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/hrhp_pkg.sv]
// Types, constants and helper functions of the HTTP response header parser.
package hrhp_pkg;

   localparam int LENGTH_BITS = 16;
   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [4:0] LINE_POS_MAX = 5'd31;
   localparam logic [4:0] LEN_NAME_LEN = 5'd15;
   localparam logic [4:0] ENC_NAME_LEN = 5'd18;
   localparam logic [2:0] CHUNK_WORD_LEN = 3'd7;

   localparam logic [15:0] STATUS_MAX = '1;
   localparam logic [31:0] CLEN_MAX = '1;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_C = 8'h63;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef enum logic [2:0] {
      PH_PRE_SPACE,
      PH_STATUS,
      PH_HEADERS,
      PH_BODY,
      PH_NO_SPACE
   } phase_type;

   typedef enum logic [1:0] {
      NUM_SKIP,
      NUM_SIGN,
      NUM_DIGITS,
      NUM_DONE
   } num_phase_type;

   typedef enum logic [1:0] {
      ERR_OK,
      ERR_NO_CRLF,
      ERR_NO_SPACE,
      ERR_UNTERMINATED
   } error_type;

   // One classified word as it travels from the front through the queue.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       crlf;
      logic       blank_line;
      logic       is_space;
      logic       is_ws;
      logic       is_digit;
      logic       is_sign;
      logic       is_minus;
      logic       is_c;
      logic       len_start;
      logic       len_active;
      logic       enc_active;
   } class_word_type;

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
         r = b + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic is_white(input logic [7:0] b);
      return (b == CH_SPACE) || (b inside {[CH_TAB:CH_CR]});
   endfunction

   function automatic logic [7:0] len_name_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:  c = "c";
         4'd1:  c = "o";
         4'd2:  c = "n";
         4'd3:  c = "t";
         4'd4:  c = "e";
         4'd5:  c = "n";
         4'd6:  c = "t";
         4'd7:  c = "-";
         4'd8:  c = "l";
         4'd9:  c = "e";
         4'd10: c = "n";
         4'd11: c = "g";
         4'd12: c = "t";
         4'd13: c = "h";
         4'd14: c = ":";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] enc_name_char(input logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0:  c = "t";
         5'd1:  c = "r";
         5'd2:  c = "a";
         5'd3:  c = "n";
         5'd4:  c = "s";
         5'd5:  c = "f";
         5'd6:  c = "e";
         5'd7:  c = "r";
         5'd8:  c = "-";
         5'd9:  c = "e";
         5'd10: c = "n";
         5'd11: c = "c";
         5'd12: c = "o";
         5'd13: c = "d";
         5'd14: c = "i";
         5'd15: c = "n";
         5'd16: c = "g";
         5'd17: c = ":";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] chunk_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = "c";
         3'd1: c = "h";
         3'd2: c = "u";
         3'd3: c = "n";
         3'd4: c = "k";
         3'd5: c = "e";
         3'd6: c = "d";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Low 16 bits of a byte count, zero-extended when the count is narrower.
   function automatic logic [15:0] fit16(input logic [LENGTH_BITS-1:0] v);
      logic [LENGTH_BITS+15:0] t;
      t = {16'd0, v};
      return t[15:0];
   endfunction

endpackage

[rtl/hrhp_req_if.sv]
// Valid/ready channel that carries one response byte per word.
interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/hrhp_rsp_if.sv]
// Valid/ready channel that carries one parse result per word.
interface hrhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  error_code;
   logic [15:0] http_status;
   logic [31:0] declared_length;
   logic        chunked_flag;
   logic [15:0] header_size;
   logic [15:0] body_size;

   modport source (output valid, output error_code, output http_status,
      output declared_length, output chunked_flag, output header_size,
      output body_size, input ready);
   modport sink (input valid, input error_code, input http_status,
      input declared_length, input chunked_flag, input header_size,
      input body_size, output ready);
endinterface

[rtl/hrhp_front.sv]
// Front end: accepts bytes, tracks line position and header-name matches.
module hrhp_front (
   input  logic                    clock,
   input  logic                    reset,
   hrhp_req_if.sink                req_ch,
   output logic                    push_valid,
   output hrhp_pkg::class_word_type push_word,
   input  logic                    push_ready
);
   import hrhp_pkg::*;

   logic       prev_cr_ff, prev_cr_in;
   logic [4:0] line_pos_ff, line_pos_in;
   logic       len_alive_ff, len_alive_in;
   logic       enc_alive_ff, enc_alive_in;

   logic [7:0] lower;
   logic       crlf;
   logic       len_in_name;
   logic       enc_in_name;
   logic       len_match;
   logic       enc_match;
   logic       accept;

   assign req_ch.ready = push_ready;
   assign push_valid = req_ch.valid;
   assign accept = req_ch.valid && push_ready;

   assign lower = to_lower(req_ch.data_byte);
   assign crlf = prev_cr_ff && (req_ch.data_byte == CH_LF);
   assign len_in_name = line_pos_ff < LEN_NAME_LEN;
   assign enc_in_name = line_pos_ff < ENC_NAME_LEN;
   assign len_match = lower == len_name_char(line_pos_ff[3:0]);
   assign enc_match = lower == enc_name_char(line_pos_ff);

   always_comb begin
      push_word.data_byte = req_ch.data_byte;
      push_word.last_byte = req_ch.last_byte;
      push_word.crlf = crlf;
      push_word.blank_line = crlf && (line_pos_ff == 5'd1);
      push_word.is_space = req_ch.data_byte == CH_SPACE;
      push_word.is_ws = is_white(req_ch.data_byte);
      push_word.is_digit = req_ch.data_byte inside {[CH_ZERO:CH_NINE]};
      push_word.is_sign = (req_ch.data_byte == CH_PLUS) || (req_ch.data_byte == CH_MINUS);
      push_word.is_minus = req_ch.data_byte == CH_MINUS;
      push_word.is_c = req_ch.data_byte == CH_LOWER_C;
      push_word.len_start = len_alive_ff && (line_pos_ff == LEN_NAME_LEN);
      push_word.len_active = len_alive_ff && !len_in_name;
      push_word.enc_active = enc_alive_ff && !enc_in_name;
   end

   always_comb begin
      prev_cr_in = prev_cr_ff;
      line_pos_in = line_pos_ff;
      len_alive_in = len_alive_ff;
      enc_alive_in = enc_alive_ff;
      if (accept) begin
         prev_cr_in = !req_ch.last_byte && (req_ch.data_byte == CH_CR);
         if (req_ch.last_byte || crlf) begin
            line_pos_in = 5'd0;
            len_alive_in = 1'b1;
            enc_alive_in = 1'b1;
         end else begin
            if (line_pos_ff != LINE_POS_MAX) begin
               line_pos_in = line_pos_ff + 5'd1;
            end
            if (len_in_name && !len_match) begin
               len_alive_in = 1'b0;
            end
            if (enc_in_name && !enc_match) begin
               enc_alive_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cr_ff <= 1'b0;
         line_pos_ff <= 5'd0;
         len_alive_ff <= 1'b1;
         enc_alive_ff <= 1'b1;
      end else begin
         prev_cr_ff <= prev_cr_in;
         line_pos_ff <= line_pos_in;
         len_alive_ff <= len_alive_in;
         enc_alive_ff <= enc_alive_in;
      end
   end

endmodule

[rtl/hrhp_queue.sv]
// Small word queue that decouples the front end from the parser back end.
`include "http_response_header_parser_macros.svh"
module hrhp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  hrhp_pkg::class_word_type push_word,
   output logic                     push_ready,
   output logic                     pop_valid,
   output hrhp_pkg::class_word_type pop_word,
   input  logic                     pop_ready
);
   import hrhp_pkg::*;

   class_word_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff, count_in;
   logic                        push;
   logic                        pop;

   localparam logic [QUEUE_CNT_BITS-1:0] FULL_COUNT = QUEUE_CNT_BITS'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_BITS-1:0] LAST_SLOT = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid = count_ff != '0;
   assign pop_word = entry_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   `HRHP_ASSERT_NEXT(a_fill_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue fill did not grow on push")

endmodule

[rtl/hrhp_back.sv]
// Back end: status line and header parsing, result register.
`include "http_response_header_parser_macros.svh"
module hrhp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   input  hrhp_pkg::class_word_type pop_word,
   output logic                     pop_ready,
   hrhp_rsp_if.source               rsp_ch
);
   import hrhp_pkg::*;

   phase_type                phase_ff, phase_in, phase_step;
   logic [LENGTH_BITS-1:0]   byte_count_ff, byte_count_in, byte_count_step;
   num_phase_type            num_phase_ff, num_phase_in, num_phase_step;
   logic                     negative_ff, negative_in, negative_step;
   logic [15:0]              status_acc_ff, status_acc_in, status_acc_step;
   logic [31:0]              length_acc_ff, length_acc_in, length_acc_step;
   logic [2:0]               chunk_idx_ff, chunk_idx_in, chunk_idx_step;
   logic                     chunked_ff, chunked_in, chunked_step;
   logic [LENGTH_BITS-1:0]   hdr_end_ff, hdr_end_in, hdr_end_step;

   logic                     rsp_valid_ff, rsp_valid_in;
   error_type                rsp_error_ff, rsp_error_in;
   logic [15:0]              rsp_status_ff, rsp_status_in;
   logic [31:0]              rsp_length_ff, rsp_length_in;
   logic                     rsp_chunked_ff, rsp_chunked_in;
   logic [15:0]              rsp_hsize_ff, rsp_hsize_in;
   logic [15:0]              rsp_bsize_ff, rsp_bsize_in;

   logic                     out_free;
   logic                     pop;
   logic                     finish;
   logic                     feed_status;
   logic                     feed_length;
   logic                     feed_chunk;
   logic                     num_start;
   num_phase_type            num_base;
   logic                     neg_base;
   logic [31:0]              length_base;
   logic [35:0]              mac_op;
   logic [35:0]              mac_sum;
   logic [35:0]              mac_cap;
   logic [31:0]              mac_result;
   logic                     acc_update;
   logic [2:0]               chunk_next;
   error_type                error_step;
   logic [LENGTH_BITS-1:0]   body_count;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign pop_ready = !pop_word.last_byte || out_free;
   assign pop = pop_valid && pop_ready;
   assign finish = pop && pop_word.last_byte;

   // Phase sequencing.
   always_comb begin
      phase_step = phase_ff;
      case (phase_ff)
         PH_PRE_SPACE: begin
            if (pop_word.crlf) begin
               phase_step = PH_NO_SPACE;
            end else if (pop_word.is_space) begin
               phase_step = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (pop_word.crlf) begin
               phase_step = PH_HEADERS;
            end
         end
         PH_HEADERS: begin
            if (pop_word.blank_line) begin
               phase_step = PH_BODY;
            end
         end
         default: phase_step = phase_ff;
      endcase
      phase_in = phase_ff;
      if (pop) begin
         phase_in = pop_word.last_byte ? PH_PRE_SPACE : phase_step;
      end
   end

   // Number decoding, chunked search, counters and the result.
   always_comb begin
      byte_count_step = (byte_count_ff == COUNT_MAX) ? byte_count_ff
                                                     : byte_count_ff + 1'b1;

      feed_status = (phase_ff == PH_STATUS) && !pop_word.crlf;
      feed_length = (phase_ff == PH_HEADERS) && !pop_word.crlf && pop_word.len_active;
      feed_chunk = (phase_ff == PH_HEADERS) && !pop_word.crlf && pop_word.enc_active;
      num_start = feed_length && pop_word.len_start;

      num_base = num_start ? NUM_SKIP : num_phase_ff;
      neg_base = num_start ? 1'b0 : negative_ff;
      length_base = num_start ? 32'd0 : length_acc_ff;

      num_phase_step = num_base;
      negative_step = neg_base;
      case (num_base)
         NUM_SKIP: begin
            if (pop_word.is_ws) begin
               num_phase_step = NUM_SKIP;
            end else if (pop_word.is_sign) begin
               num_phase_step = NUM_SIGN;
               negative_step = pop_word.is_minus;
            end else begin
               num_phase_step = pop_word.is_digit ? NUM_DIGITS : NUM_DONE;
            end
         end
         NUM_SIGN: num_phase_step = pop_word.is_digit ? NUM_DIGITS : NUM_DONE;
         NUM_DIGITS: num_phase_step = pop_word.is_digit ? NUM_DIGITS : NUM_DONE;
         default: num_phase_step = NUM_DONE;
      endcase
      acc_update = (num_phase_step == NUM_DIGITS) && !negative_step;

      // One shared times-ten-plus-digit unit serves both numbers.
      mac_op = feed_status ? {20'd0, status_acc_ff} : {4'd0, length_base};
      mac_sum = (mac_op << 3) + (mac_op << 1) + {32'd0, pop_word.data_byte[3:0]};
      mac_cap = feed_status ? {20'd0, STATUS_MAX} : {4'd0, CLEN_MAX};
      mac_result = (mac_sum > mac_cap) ? mac_cap[31:0] : mac_sum[31:0];

      status_acc_step = status_acc_ff;
      length_acc_step = length_acc_ff;
      if (feed_status) begin
         if (acc_update) begin
            status_acc_step = mac_result[15:0];
         end
      end else if (feed_length) begin
         length_acc_step = acc_update ? mac_result : length_base;
      end

      if (!feed_status && !feed_length) begin
         num_phase_step = num_phase_ff;
         negative_step = negative_ff;
         if ((phase_ff == PH_PRE_SPACE) && !pop_word.crlf && pop_word.is_space) begin
            num_phase_step = NUM_SKIP;
            negative_step = 1'b0;
         end
      end

      chunk_next = chunk_idx_ff + 3'd1;
      chunk_idx_step = chunk_idx_ff;
      chunked_step = chunked_ff;
      if (pop_word.crlf) begin
         chunk_idx_step = 3'd0;
      end else if (feed_chunk) begin
         if (pop_word.data_byte == chunk_char(chunk_idx_ff)) begin
            if (chunk_next >= CHUNK_WORD_LEN) begin
               chunked_step = 1'b1;
               chunk_idx_step = 3'd0;
            end else begin
               chunk_idx_step = chunk_next;
            end
         end else begin
            chunk_idx_step = pop_word.is_c ? 3'd1 : 3'd0;
         end
      end

      hdr_end_step = hdr_end_ff;
      if ((phase_ff == PH_HEADERS) && pop_word.blank_line) begin
         hdr_end_step = byte_count_step;
      end
      body_count = byte_count_step - hdr_end_step;

      case (phase_step)
         PH_PRE_SPACE: error_step = ERR_NO_CRLF;
         PH_STATUS: error_step = ERR_NO_CRLF;
         PH_NO_SPACE: error_step = ERR_NO_SPACE;
         PH_HEADERS: error_step = ERR_UNTERMINATED;
         default: error_step = ERR_OK;
      endcase

      byte_count_in = byte_count_ff;
      num_phase_in = num_phase_ff;
      negative_in = negative_ff;
      status_acc_in = status_acc_ff;
      length_acc_in = length_acc_ff;
      chunk_idx_in = chunk_idx_ff;
      chunked_in = chunked_ff;
      hdr_end_in = hdr_end_ff;
      if (finish) begin
         byte_count_in = '0;
         num_phase_in = NUM_SKIP;
         negative_in = 1'b0;
         status_acc_in = 16'd0;
         length_acc_in = 32'd0;
         chunk_idx_in = 3'd0;
         chunked_in = 1'b0;
         hdr_end_in = '0;
      end else if (pop) begin
         byte_count_in = byte_count_step;
         num_phase_in = num_phase_step;
         negative_in = negative_step;
         status_acc_in = status_acc_step;
         length_acc_in = length_acc_step;
         chunk_idx_in = chunk_idx_step;
         chunked_in = chunked_step;
         hdr_end_in = hdr_end_step;
      end

      rsp_valid_in = finish || (rsp_valid_ff && !rsp_ch.ready);
      rsp_error_in = rsp_error_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      rsp_chunked_in = rsp_chunked_ff;
      rsp_hsize_in = rsp_hsize_ff;
      rsp_bsize_in = rsp_bsize_ff;
      if (finish) begin
         rsp_error_in = error_step;
         if (error_step == ERR_OK) begin
            rsp_status_in = status_acc_step;
            rsp_length_in = length_acc_step;
            rsp_chunked_in = chunked_step;
            rsp_hsize_in = fit16(hdr_end_step);
            rsp_bsize_in = fit16(body_count);
         end else begin
            rsp_status_in = 16'd0;
            rsp_length_in = 32'd0;
            rsp_chunked_in = 1'b0;
            rsp_hsize_in = 16'd0;
            rsp_bsize_in = 16'd0;
         end
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.error_code = rsp_error_ff;
   assign rsp_ch.http_status = rsp_status_ff;
   assign rsp_ch.declared_length = rsp_length_ff;
   assign rsp_ch.chunked_flag = rsp_chunked_ff;
   assign rsp_ch.header_size = rsp_hsize_ff;
   assign rsp_ch.body_size = rsp_bsize_ff;

   always_ff @(posedge clock) begin
      rsp_error_ff <= rsp_error_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
      rsp_chunked_ff <= rsp_chunked_in;
      rsp_hsize_ff <= rsp_hsize_in;
      rsp_bsize_ff <= rsp_bsize_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PRE_SPACE;
         byte_count_ff <= '0;
         num_phase_ff <= NUM_SKIP;
         negative_ff <= 1'b0;
         status_acc_ff <= 16'd0;
         length_acc_ff <= 32'd0;
         chunk_idx_ff <= 3'd0;
         chunked_ff <= 1'b0;
         hdr_end_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         byte_count_ff <= byte_count_in;
         num_phase_ff <= num_phase_in;
         negative_ff <= negative_in;
         status_acc_ff <= status_acc_in;
         length_acc_ff <= length_acc_in;
         chunk_idx_ff <= chunk_idx_in;
         chunked_ff <= chunked_in;
         hdr_end_ff <= hdr_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `HRHP_ASSERT_NEXT(a_last_gives_result, clock, reset, finish,
      rsp_valid_ff && (phase_ff == PH_PRE_SPACE) && (byte_count_ff == '0),
      "last word did not produce a result and restart")
   `HRHP_ASSERT_NOW(a_error_clears_fields, clock, reset,
      rsp_valid_ff && (rsp_error_ff != ERR_OK),
      (rsp_status_ff == 16'd0) && (rsp_length_ff == 32'd0) && !rsp_chunked_ff
         && (rsp_hsize_ff == 16'd0) && (rsp_bsize_ff == 16'd0),
      "error result carries nonzero fields")
   `HRHP_ASSERT_NOW(a_body_has_header, clock, reset, phase_ff == PH_BODY,
      hdr_end_ff != '0, "body phase without a header end offset")

endmodule

[rtl/http_response_header_parser.sv]
// Top level of the streaming HTTP response header parser.
// Usage: bytes of one HTTP response enter on req_ch, one byte per word, with
// last_byte set on the final byte of the response. Nothing comes out for the
// other bytes. For the final byte exactly one word leaves on rsp_ch: the error
// code, the decimal status code, the Content-Length value, the chunked flag,
// the header size up to and including the blank line, and the body size.
// After the final byte the parser starts over, so responses may follow each
// other without a gap.
// Throughput is one byte per clock cycle while the receiver takes results.
// The front end classifies each byte and tracks the line position and the
// header-name matches, a four-word queue holds classified bytes, and the back
// end advances the parse state once per byte with a single
// times-ten-plus-digit unit for both decimal numbers. The final byte is
// registered in the queue, and its result word in the rsp_ch output register.
// Reset (synchronous, active high) clears the parse state, empties the queue
// and drops rsp_ch.valid. When the receiver stalls, the result stays in the
// output register; bytes of the next response keep flowing into the back end
// until a second final byte reaches it, and then the queue fills and
// req_ch.ready falls.
module http_response_header_parser (
   input  logic       clock,
   input  logic       reset,
   hrhp_req_if.sink   req_ch,
   hrhp_rsp_if.source rsp_ch
);
   import hrhp_pkg::*;

   // Classified words between the front end and the queue.
   logic           push_valid;
   logic           push_ready;
   class_word_type push_word;

   // Classified words between the queue and the back end.
   logic           pop_valid;
   logic           pop_ready;
   class_word_type pop_word;

   hrhp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready)
   );

   hrhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .pop_ready  (pop_ready)
   );

   hrhp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_word  (pop_word),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule
